[rtl/ktmp_pkg.sv]
// Shared constants and types for the k-transaction stock profit block.
`default_nettype none
package ktmp_pkg;

    localparam int MAX_TRANS = 128;
    localparam int IDX_W     = $clog2(MAX_TRANS);
    localparam int K_W       = 8;
    localparam int PRICE_W   = 16;
    localparam int ACC_W     = 32;
    localparam int PROFIT_W  = 31;
    localparam int ENTRY_W   = 2 * ACC_W;

    localparam logic [K_W-1:0] K_SAT = K_W'(MAX_TRANS);

    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

    typedef logic [PRICE_W-1:0]       price_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [K_W-1:0]           k_t;
    typedef logic [PROFIT_W-1:0]      profit_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREF = 5'b00010,
        ST_HOLD = 5'b00100,
        ST_FREE = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage
`default_nettype wire

[rtl/ktmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ktmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/ktmp_alu.sv]
// Shared saturating add/subtract and max unit.
`default_nettype none
module ktmp_alu (
    input  wire ktmp_pkg::acc_t   acc,
    input  wire ktmp_pkg::price_t price,
    input  wire logic             sub,
    input  wire ktmp_pkg::acc_t   cur,
    output ktmp_pkg::acc_t        res
);
    import ktmp_pkg::*;

    logic signed [ACC_W:0] ext_acc;
    logic signed [ACC_W:0] ext_price;
    logic signed [ACC_W:0] sum;
    acc_t                  sat;

    always_comb begin
        ext_acc   = {acc[ACC_W-1], acc};
        ext_price = {{(ACC_W+1-PRICE_W){1'b0}}, price};
        sum       = sub ? (ext_acc - ext_price) : (ext_acc + ext_price);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat = sum[ACC_W-1:0];
        end
        res = (sat > cur) ? sat : cur;
    end

endmodule
`default_nettype wire

[rtl/k_transaction_max_profit_dp.sv]
// Top level: best profit from at most k buy-then-sell transactions.
//
// Input channel s_valid/s_ready carries one price per beat; s_last_price marks
// the final day of a sequence. Result channel m_valid/m_ready carries one
// m_best_gain beat per sequence, produced after the last price. The user must
// write k via cfg_wr_en/cfg_wr_data (saturated to 128) only while the block is
// idle; the block itself does not enforce this.
// Each price walks the transaction entries 1..k in order on the shared
// add/compare unit, each entry taking a holding update (ST_HOLD) then a free
// update (ST_FREE), plus a prefetch state (ST_PREF), a finishing state
// (ST_EMIT) and the idle state that takes the beat; at k = 0 only ST_EMIT
// follows the beat. The result register loads in ST_EMIT after the last price.
// s_ready is high only when the sequencer is idle.
// Per-entry state lives in one 128 x 64 RAM; a valid bit per entry marks
// written entries, unwritten ones read as holding = -2^31, free = 0.
//
// Reset (aresetn low, synchronous) sets k to 1, clears all valid bits and the
// result valid flag. After a last price, ST_EMIT clears the valid bits.
// If the result register is still full when a sequence ends, the block waits
// until m_ready drains it; a non-final price never waits.
`default_nettype none
module k_transaction_max_profit_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire ktmp_pkg::k_t       cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ktmp_pkg::price_t   s_price,
    input  wire logic               s_last_price,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ktmp_pkg::profit_t       m_best_gain
);
    import ktmp_pkg::*;

    state_t                 state_reg, state_next;
    k_t                     cfg_k_reg;
    k_t                     k_reg, k_next;
    idx_t                   idx_reg, idx_next;
    price_t                 price_reg, price_next;
    logic                   last_reg, last_next;
    acc_t                   prev_free_reg, prev_free_next;
    acc_t                   hold_new_reg, hold_new_next;
    logic [MAX_TRANS-1:0]   valid_reg, valid_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   m_valid_reg, m_valid_next;
    profit_t                m_profit_reg, m_profit_next;

    logic                   rd_en;
    idx_t                   rd_addr;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   wr_en;
    logic [ENTRY_W-1:0]     wr_data;
    acc_t                   hold_old;
    acc_t                   free_old;
    acc_t                   alu_acc;
    acc_t                   alu_cur;
    logic                   alu_sub;
    acc_t                   alu_res;
    k_t                     idx_inc;
    logic                   at_end;
    k_t                     k_in;

    ktmp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ktmp_alu u_alu (
        .acc   (alu_acc),
        .price (price_reg),
        .sub   (alu_sub),
        .cur   (alu_cur),
        .res   (alu_res)
    );

    always_comb begin
        hold_old = rd_valid_reg ? acc_t'(rd_data[ENTRY_W-1:ACC_W]) : ACC_MIN;
        free_old = rd_valid_reg ? acc_t'(rd_data[ACC_W-1:0]) : '0;
        alu_sub  = (state_reg == ST_HOLD);
        alu_acc  = alu_sub ? prev_free_reg : hold_new_reg;
        alu_cur  = alu_sub ? hold_old : free_old;
        idx_inc  = {1'b0, idx_reg} + K_W'(1);
        at_end   = (idx_inc == k_reg);
        k_in     = (cfg_k_reg > K_SAT) ? K_SAT : cfg_k_reg;
        wr_data  = {hold_new_reg, alu_res};
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        price_next     = price_reg;
        last_next      = last_reg;
        prev_free_next = prev_free_reg;
        hold_new_next  = hold_new_reg;
        valid_next     = valid_reg;
        rd_valid_next  = rd_valid_reg;
        m_valid_next   = m_valid_reg;
        m_profit_next  = m_profit_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        s_ready        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    price_next     = s_price;
                    last_next      = s_last_price;
                    k_next         = k_in;
                    idx_next       = '0;
                    prev_free_next = '0;
                    state_next     = (k_in == '0) ? ST_EMIT : ST_PREF;
                end
            end
            ST_PREF: begin
                rd_en         = 1'b1;
                rd_valid_next = valid_reg[idx_reg];
                state_next    = ST_HOLD;
            end
            ST_HOLD: begin
                hold_new_next = alu_res;
                state_next    = ST_FREE;
            end
            ST_FREE: begin
                wr_en              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                prev_free_next     = alu_res;
                if (at_end) begin
                    state_next = ST_EMIT;
                end else begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_inc[IDX_W-1:0];
                    rd_valid_next = valid_reg[idx_inc[IDX_W-1:0]];
                    idx_next      = idx_inc[IDX_W-1:0];
                    state_next    = ST_HOLD;
                end
            end
            ST_EMIT: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_profit_next = prev_free_reg[PROFIT_W-1:0];
                    valid_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_k_reg   <= K_W'(1);
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_k_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        idx_reg       <= idx_next;
        price_reg     <= price_next;
        last_reg      <= last_next;
        prev_free_reg <= prev_free_next;
        hold_new_reg  <= hold_new_next;
        rd_valid_reg  <= rd_valid_next;
        m_profit_reg  <= m_profit_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_best_gain = m_profit_reg;

endmodule
`default_nettype wire

[test/tb_k_transaction_max_profit_dp.sv]
// Testbench for k_transaction_max_profit_dp: price beats checked against a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_k_transaction_max_profit_dp;
    import ktmp_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 300;

    class profit_board;
        acc_t    hold_best [MAX_TRANS];
        acc_t    free_best [MAX_TRANS];
        k_t      k_reg;
        profit_t want [$];
        int      errors;

        function new();
            clear_days();
            k_reg  = 1;
            errors = 0;
        endfunction

        function void clear_days();
            foreach (hold_best[i]) begin
                hold_best[i] = ACC_MIN;
                free_best[i] = '0;
            end
        endfunction

        function acc_t sat_acc(longint v);
            if (v > longint'(ACC_MAX)) return ACC_MAX;
            if (v < longint'(ACC_MIN)) return ACC_MIN;
            return acc_t'(v);
        endfunction

        function void set_k(k_t v);
            k_reg = v;
        endfunction

        // Walk entries 1..k for one price; on the last day queue free[k] and clear.
        function void note_beat(price_t price, logic last);
            int     n;
            int     j;
            longint prev_free;
            longint cand;
            longint best;
            n = (k_reg > K_SAT) ? MAX_TRANS : int'(k_reg);
            prev_free = 0;
            for (j = 0; j < n; j++) begin
                cand = longint'(sat_acc(prev_free - longint'(price)));
                if (cand > longint'(hold_best[j])) hold_best[j] = acc_t'(cand);
                cand = longint'(sat_acc(longint'(hold_best[j]) + longint'(price)));
                if (cand > longint'(free_best[j])) free_best[j] = acc_t'(cand);
                prev_free = longint'(free_best[j]);
            end
            if (last) begin
                best = (n > 0) ? longint'(free_best[n-1]) : 0;
                if (best < 0) best = 0;
                want.push_back(profit_t'(best));
                clear_days();
            end
        endfunction

        function void check_beat(profit_t got);
            profit_t exp_profit;
            if (want.size() == 0) begin
                $display("%0t: unexpected best gain beat, expected none, actual %0d",
                         $time, got);
                errors++;
            end else begin
                exp_profit = want.pop_front();
                if (got !== exp_profit) begin
                    $display("%0t: best gain mismatch, expected %0d, actual %0d",
                             $time, exp_profit, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    cfg_wr_en;
    k_t      cfg_wr_data;
    logic    s_valid;
    logic    s_ready;
    price_t  s_price;
    logic    s_last_price;
    logic    m_valid;
    logic    m_ready;
    profit_t m_best_gain;

    int          src_idle;
    int          sink_idle;
    int          cycles;
    profit_board board;

    k_transaction_max_profit_dp DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_price      (s_price),
        .s_last_price (s_last_price),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_gain  (m_best_gain)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: check each accepted beat, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_beat(m_best_gain);
        m_ready <= ($urandom_range(99) >= sink_idle);
    end

    task automatic send_price(price_t price, logic last);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_price      <= price;
        s_last_price <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_beat(price, last);
    endtask

    // Let every result drain and the sequencer finish before touching k
    task automatic settle();
        s_valid <= 1'b0;
        while (board.want.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_k(k_t v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_k(v);
    endtask

    task automatic send_days(price_t days [$]);
        int i;
        for (i = 0; i < days.size(); i++)
            send_price(days[i], i == days.size() - 1);
    endtask

    function automatic k_t pick_k();
        int r;
        r = $urandom_range(19);
        if (r == 0) return k_t'($urandom_range(129, 255));
        if (r == 1) return K_SAT;
        if (r < 4)  return k_t'($urandom_range(17, 127));
        return k_t'($urandom_range(0, 16));
    endfunction

    task automatic run_random(int n_items);
        int     sent;
        int     len;
        int     mode;
        int     base;
        int     i;
        int     p;
        price_t price;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) write_k(pick_k());
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            mode = $urandom_range(2);
            base = $urandom_range(0, 65535);
            for (i = 0; i < len; i++) begin
                case (mode)
                    0: price = price_t'($urandom_range(0, 65535));
                    1: price = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: begin
                        p = base + $urandom_range(0, 30) - 15;
                        if (p < 0) p = 0;
                        if (p > 65535) p = 65535;
                        price = price_t'(p);
                    end
                endcase
                send_price(price, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        board        = new();
        cycles       = 0;
        src_idle     = 0;
        sink_idle    = 0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_price      = '0;
        s_last_price = 1'b0;
        m_ready      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: k = 1 from reset
        send_days({16'd0});
        send_days({16'd0, 16'hFFFF});
        send_days({16'hFFFF, 16'd0});
        write_k(8'd0);
        send_days({16'd5, 16'd60000});
        write_k(8'd2);
        send_days({16'd1, 16'd9, 16'd2, 16'd50, 16'd7});
        write_k(8'd255);
        send_days({16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
        write_k(8'd128);
        send_days({16'd30000, 16'd30000});
        write_k(8'd3);
        send_price(16'd10, 1'b0);
        send_price(16'd50, 1'b0);
        write_k(8'd1);       // k changed part way through a sequence
        send_price(16'd20, 1'b0);
        send_price(16'd90, 1'b1);
        write_k(8'd129);
        send_days({16'd7});

        src_idle = 30; sink_idle = 60;
        run_random(300);
        src_idle = 60; sink_idle = 30;
        run_random(300);
        src_idle = 0;  sink_idle = 0;
        run_random(300);

        settle();
        if (board.errors == 0 && board.want.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/ktmp_pkg.sv
rtl/ktmp_ram.sv
rtl/ktmp_alu.sv
rtl/k_transaction_max_profit_dp.sv
test/tb_k_transaction_max_profit_dp.sv
